### src/rte_pkg.sv
package rte_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int RTT_W         = 32;
  localparam int GAIN_W        = 17;
  localparam int GAIN_FRAC     = 16;
  localparam int SEC_W         = 15;
  localparam int USEC_W        = 20;
  // microseconds of the timeout: (est + 4*dev) >> frac fits in 32 + 3 bits
  localparam int US_W          = RTT_W + 3;
  localparam int MUL_CHUNK     = 28;
  localparam int CFG_IDX_W     = 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE     = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] ALPHA_RESET  = GAIN_W'(8192);
  localparam logic [GAIN_W-1:0] BETA_RESET   = GAIN_W'(16384);
  localparam int                USEC_PER_SEC = 1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 1'b1;

  typedef struct packed {
    logic [RTT_W-1:0] sample_rtt_us;
  } in_item_t;

  typedef struct packed {
    logic [SEC_W-1:0]  timeout_sec;
    logic [USEC_W-1:0] timeout_usec;
    logic [RTT_W-1:0]  smoothed_rtt_us;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_UPD,
    ST_ERR,
    ST_TOT,
    ST_DIV,
    ST_OUT
  } seq_state_t;

  function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

endpackage

### src/rte_stream_if.sv
interface rte_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/rte_gain_mul.sv
module rte_gain_mul #(
  parameter int STATE_W = 32 + rte_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [STATE_W-1:0]        x,
  input  logic [rte_pkg::GAIN_W-1:0] g,
  output logic [STATE_W-1:0]        res,
  output rte_pkg::unit_stat_t       stat
);
  import rte_pkg::*;

  localparam int NCHUNK = (STATE_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int XW     = NCHUNK * MUL_CHUNK;
  localparam int AW     = XW + GAIN_W;
  localparam int PW     = MUL_CHUNK + GAIN_W;
  localparam int CW     = $clog2(NCHUNK + 1);

  logic [XW-1:0]     x_r;
  logic [GAIN_W-1:0] g_r;
  logic [AW-1:0]     acc_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [PW-1:0]     prod;

  // top chunk first, so the running sum only ever shifts by a constant
  assign prod = x_r[XW-1 -: MUL_CHUNK] * g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NCHUNK);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= XW'(x);
      g_r   <= g;
      acc_r <= '0;
    end else if (busy_r) begin
      x_r   <= x_r << MUL_CHUNK;
      acc_r <= (acc_r << MUL_CHUNK) + AW'(prod);
    end
  end

  assign res       = acc_r[GAIN_FRAC +: STATE_W];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### src/rte_sec_split.sv
module rte_sec_split (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rte_pkg::US_W-1:0]   dividend,
  output logic [rte_pkg::SEC_W-1:0]  quot,
  output logic [rte_pkg::USEC_W-1:0] rem,
  output rte_pkg::unit_stat_t        stat
);
  import rte_pkg::*;

  // 1e6 = 15625 << 6: drop the six low bits, then divide by 15625 with a
  // reciprocal multiply that is exact for every NW-bit input
  localparam int POW2_SH = 6;
  localparam int ODD_W   = 14;
  localparam int NW      = US_W - POW2_SH;
  localparam int RCP_W   = 30;
  localparam int RCP_SH  = 43;
  localparam logic [ODD_W-1:0] ODD_DIV = ODD_W'(USEC_PER_SEC >> POW2_SH);
  // ceil(2^43 / 15625)
  localparam logic [RCP_W-1:0] RCP     = RCP_W'(562949954);

  logic [NW-1:0]       n_r;
  logic [POW2_SH-1:0]  lo_r;
  logic [SEC_W-1:0]    q_r;
  logic [ODD_W-1:0]    r_r;
  logic                busy_r, done_r, step_r;
  logic [NW+RCP_W-1:0] qprod;
  logic [NW-1:0]       qback, rdiff;

  assign qprod = n_r * RCP;
  assign qback = q_r * ODD_DIV;
  assign rdiff = n_r - qback;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 1'b0;
      end else if (busy_r) begin
        step_r <= 1'b1;
        if (step_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // step 0: quotient from the reciprocal, step 1: remainder by back-multiply
  always_ff @(posedge clk) begin
    if (start) begin
      n_r  <= dividend[US_W-1:POW2_SH];
      lo_r <= dividend[POW2_SH-1:0];
    end else if (busy_r) begin
      if (!step_r) q_r <= qprod[RCP_SH +: SEC_W];
      else         r_r <= rdiff[ODD_W-1:0];
    end
  end

  assign quot      = q_r;
  assign rem       = {r_r, lo_r};
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### src/rtt_timeout_estimator.sv
// channel | dir | handshake     | payload
// in_ch   | in  | valid / ready | sample_rtt_us[31:0]
// out_ch  | out | valid / ready | timeout_sec[14:0], timeout_usec[19:0], smoothed_rtt_us[31:0]
// cfg     | in  | cfg_wen       | cfg_index[0], cfg_wdata[16:0] (alpha, beta gains)
//
// One sample at a time: from accept until the result is registered, the sequencer runs
// the shared 28x17 gain multiplier (two passes) over NCHUNK = ceil((32+FRAC_BITS)/28)
// chunks of the difference each time, then the two-step seconds split.
// Synchronous active-low reset clears state, gains go to 0.125 / 0.25.
// The result register holds until taken; a new sample is accepted meanwhile, and
// its result waits in the sequencer if the previous one is still pending.
module rtt_timeout_estimator #(
  parameter int FRAC_BITS = rte_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  rte_stream_if.sink                    in_ch,
  rte_stream_if.source                  out_ch,
  input  logic                          cfg_wen,
  input  logic [rte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rte_pkg::GAIN_W-1:0]    cfg_wdata
);
  import rte_pkg::*;

  localparam int W  = RTT_W + FRAC_BITS;
  localparam int TW = W + 3;

  seq_state_t        state_r, state_nxt;
  logic [GAIN_W-1:0] alpha_r, beta_r;
  logic [W-1:0]      est_r, dev_r, samp_r, err_r;
  logic              up_r, phase_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [W-1:0]      cur, tgt, diff, upd, err;
  logic [TW-1:0]     total;
  logic              up;
  logic              accept, load_out;
  logic              mul_start, div_start;
  logic [W-1:0]      mul_res;
  logic [SEC_W-1:0]  div_quot;
  logic [USEC_W-1:0] div_rem;
  unit_stat_t        mul_stat, div_stat;

  assign accept   = in_ch.valid && in_ch.ready;
  assign load_out = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // phase 0 smooths the estimate toward the sample, phase 1 the deviation toward the error
  assign cur   = phase_r ? dev_r : est_r;
  assign tgt   = phase_r ? err_r : samp_r;
  assign up    = (tgt >= cur);
  assign diff  = up ? tgt - cur : cur - tgt;
  assign upd   = up_r ? cur + mul_res : cur - mul_res;
  assign err   = (samp_r >= est_r) ? samp_r - est_r : est_r - samp_r;
  assign total = TW'(est_r) + {1'b0, dev_r, 2'b00};

  assign mul_start = (state_r == ST_DIFF);
  assign div_start = (state_r == ST_TOT);

  rte_gain_mul #(
    .STATE_W (W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (diff),
    .g     (phase_r ? sat_gain(beta_r) : sat_gain(alpha_r)),
    .res   (mul_res),
    .stat  (mul_stat)
  );

  rte_sec_split u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total[TW-1:FRAC_BITS]),
    .quot     (div_quot),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_MUL;
      ST_MUL:  if (mul_stat.done) state_nxt = ST_UPD;
      ST_UPD:  state_nxt = phase_r ? ST_TOT : ST_ERR;
      ST_ERR:  state_nxt = ST_DIFF;
      ST_TOT:  state_nxt = ST_DIV;
      ST_DIV:  if (div_stat.done) state_nxt = ST_OUT;
      ST_OUT:  if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      alpha_r     <= ALPHA_RESET;
      beta_r      <= BETA_RESET;
      est_r       <= '0;
      dev_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        unique case (cfg_index)
          CFG_ALPHA: alpha_r <= cfg_wdata;
          CFG_BETA:  beta_r  <= cfg_wdata;
          default:   ;
        endcase
      end
      if (accept) phase_r <= 1'b0;
      else if (state_r == ST_ERR) phase_r <= 1'b1;
      if (state_r == ST_UPD) begin
        if (phase_r) dev_r <= upd;
        else         est_r <= upd;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) samp_r <= {in_ch.data.sample_rtt_us, FRAC_BITS'(0)};
    if (state_r == ST_DIFF) up_r <= up;
    if (state_r == ST_ERR) err_r <= err;
    if (load_out) begin
      out_r.timeout_sec     <= div_quot;
      out_r.timeout_usec    <= div_rem;
      out_r.smoothed_rtt_us <= est_r[W-1:FRAC_BITS];
    end
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_DIFF) && !phase_r)
    else $error("transaction accepted but sequencer did not start the estimate pass");

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mul_stat.busy && !div_stat.busy)
    else $error("arithmetic unit busy while sequencer idle");

  a_est_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && !phase_r) |=>
      ((est_r >= $past(est_r) && est_r <= samp_r) ||
       (est_r <= $past(est_r) && est_r >= samp_r)))
    else $error("estimate left the interval between old value and sample");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_OUT)
    else $error("result valid raised outside output state");

endmodule

### tb/tb_rtt_timeout_estimator.sv
module tb_rtt_timeout_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  import rte_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int STATE_W        = RTT_W + FRAC;
  localparam int RESULT_LATENCY = 30;
  localparam int IDLE_LIMIT     = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 200;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0] cfg_wdata;

  rte_stream_if #(.payload_t(in_item_t))  in_if ();
  rte_stream_if #(.payload_t(out_item_t)) out_if ();

  rtt_timeout_estimator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if.sink),
    .out_ch    (out_if.source),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // estimator copy: gains and Q32.16 state
  logic [GAIN_W-1:0]  alpha_gain_q = ALPHA_RESET;
  logic [GAIN_W-1:0]  beta_gain_q  = BETA_RESET;
  logic [STATE_W-1:0] est_q16 = '0;
  logic [STATE_W-1:0] dev_q16 = '0;

  logic [RTT_W-1:0] sample_q[$];
  out_item_t        timeout_q[$];

  int  samples_taken = 0;
  int  results_seen  = 0;
  int  mismatches    = 0;
  int  gain_writes   = 0;
  int  idle_cycles   = 0;
  int  in_gap        = 0;
  int  out_stall     = 0;
  bit  in_taken      = 1'b0;
  bit  no_idle       = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // step from cur toward target by gain g (Q1.16), product truncated
  function automatic logic [STATE_W-1:0] toward(input logic [STATE_W-1:0] cur,
                                                input logic [STATE_W-1:0] target,
                                                input logic [GAIN_W-1:0]  g);
    logic [GAIN_W-1:0]          gs;
    logic [STATE_W+GAIN_W-1:0]  prod;
    gs = (g > GAIN_ONE) ? GAIN_ONE : g;
    if (target >= cur) begin
      prod = (target - cur) * gs;
      return cur + STATE_W'(prod >> GAIN_FRAC);
    end
    prod = (cur - target) * gs;
    return cur - STATE_W'(prod >> GAIN_FRAC);
  endfunction

  task automatic predict_timeout(input logic [RTT_W-1:0] rtt_us);
    logic [STATE_W-1:0] sample;
    logic [STATE_W-1:0] err;
    logic [STATE_W+2:0] total;
    logic [US_W-1:0]    us;
    out_item_t          exp_item;
    sample  = {rtt_us, {FRAC{1'b0}}};
    est_q16 = toward(est_q16, sample, alpha_gain_q);
    err     = (sample >= est_q16) ? sample - est_q16 : est_q16 - sample;
    dev_q16 = toward(dev_q16, err, beta_gain_q);
    total   = {3'b000, est_q16} + {1'b0, dev_q16, 2'b00};
    us      = US_W'(total >> FRAC);
    exp_item.timeout_sec     = SEC_W'(us / USEC_PER_SEC);
    exp_item.timeout_usec    = USEC_W'(us % USEC_PER_SEC);
    exp_item.smoothed_rtt_us = est_q16[STATE_W-1:FRAC];
    timeout_q.push_back(exp_item);
  endtask

  // input side: accept at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      predict_timeout(in_if.data.sample_rtt_us);
      samples_taken++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      in_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else begin
        in_if.data.sample_rtt_us <= sample_q.pop_front();
        in_if.valid <= 1'b1;
        in_gap = pick_gap();
      end
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 99) < 20) out_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (timeout_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %p", $time, out_if.data);
      end else begin
        exp_item = timeout_q.pop_front();
        if (out_if.data.timeout_sec !== exp_item.timeout_sec) begin
          mismatches++;
          $display("%0t: timeout_sec expected %0d actual %0d", $time,
                   exp_item.timeout_sec, out_if.data.timeout_sec);
        end
        if (out_if.data.timeout_usec !== exp_item.timeout_usec) begin
          mismatches++;
          $display("%0t: timeout_usec expected %0d actual %0d", $time,
                   exp_item.timeout_usec, out_if.data.timeout_usec);
        end
        if (out_if.data.smoothed_rtt_us !== exp_item.smoothed_rtt_us) begin
          mismatches++;
          $display("%0t: smoothed_rtt_us expected %0d actual %0d", $time,
                   exp_item.smoothed_rtt_us, out_if.data.smoothed_rtt_us);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
                 idle_cycles, timeout_q.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_if.valid || timeout_q.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY) @(negedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (idx == CFG_ALPHA) alpha_gain_q = val;
    else beta_gain_q = val;
    gain_writes++;
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return GAIN_W'(1);
      2: return GAIN_ONE;
      3: return GAIN_ONE + GAIN_W'(1);
      4: return '1;
      5: return ALPHA_RESET;
      default: return GAIN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // mostly jittered samples around a slowly moving path delay, plus outliers
  task automatic random_burst(input int count);
    longint base;
    longint spread;
    longint val;
    int     r;
    base   = longint'($urandom >> $urandom_range(0, 31));
    spread = base >> $urandom_range(2, 6);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        base   = longint'($urandom >> $urandom_range(0, 31));
        spread = base >> $urandom_range(2, 6);
      end
      if (r < 80) begin
        val = base - spread + longint'($urandom_range(0, 32'(2 * spread)));
        if (val > 64'hFFFF_FFFF) val = 64'hFFFF_FFFF;
        sample_q.push_back(RTT_W'(val));
      end else if (r < 92) begin
        sample_q.push_back($urandom);
      end else if (r < 96) begin
        sample_q.push_back('0);
      end else begin
        sample_q.push_back('1);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wen      = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset gains; first sample seeds from zero state
    sample_q.push_back(32'd1000);
    sample_q.push_back(32'd1000);
    sample_q.push_back('0);
    sample_q.push_back('1);
    sample_q.push_back('0);
    sample_q.push_back(32'hAAAA_AAAA);
    sample_q.push_back(32'h5555_5555);
    sample_q.push_back(32'd1);
    wait_idle();

    // unity gains pull the estimate to full scale
    write_gain(CFG_ALPHA, GAIN_ONE);
    write_gain(CFG_BETA, GAIN_ONE);
    sample_q.push_back('1);
    wait_idle();
    // near-frozen estimate vs. zero sample: largest timeout
    write_gain(CFG_ALPHA, GAIN_W'(1));
    sample_q.push_back('0);
    sample_q.push_back('0);
    wait_idle();

    // gains above one saturate
    write_gain(CFG_ALPHA, '1);
    write_gain(CFG_BETA, '0);
    sample_q.push_back(32'd123456);
    sample_q.push_back('0);
    sample_q.push_back('1);
    wait_idle();
    write_gain(CFG_ALPHA, '0);
    write_gain(CFG_BETA, GAIN_ONE + GAIN_W'(1));
    sample_q.push_back(32'd5000);
    sample_q.push_back('1);
    sample_q.push_back('0);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        write_gain(CFG_ALPHA, ALPHA_RESET);
        write_gain(CFG_BETA, BETA_RESET);
      end else begin
        write_gain(CFG_ALPHA, pick_gain());
        write_gain(CFG_BETA, pick_gain());
      end
      no_idle = (p == 2);
      random_burst(PHASE_ITEMS);
      wait_idle();
    end

    wait_idle();
    $display("Ran %0d RTT samples over %0d gain writes (zero, unity and saturated gains),",
             samples_taken, gain_writes);
    $display("%0d timeouts checked, full-scale samples and largest timeout included.",
             results_seen);
    if (mismatches == 0 && timeout_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, timeout_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
